### design/clni_pkg.sv
// types, constants and the microcode table of the character lcd nibble interface
// used by every module of the block; depends on nothing
`default_nettype none

package clni_pkg;

  localparam int unsigned PC_W = 5;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  localparam logic [15:0] WAIT_POWER_UP = 16'd40000;
  localparam logic [15:0] WAIT_FIRST_EXTRA = 16'd5000;
  localparam logic [15:0] WAIT_SECOND_EXTRA = 16'd105;

  localparam logic [5:0] RST_CHARS_PER_LINE = 6'd16;
  localparam logic [7:0] RST_SECOND_LINE_CMD = 8'hC0;
  localparam logic [9:0] RST_STROBE_SETTLE = 10'd100;
  localparam logic [13:0] RST_SLOW_WAIT = 14'd1700;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_CMD   = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_HOME  = 3'd3,
    MODE_TEXT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    REG_CHARS_PER_LINE = 2'd0,
    REG_SECOND_LINE    = 2'd1,
    REG_STROBE_SETTLE  = 2'd2,
    REG_SLOW_WAIT      = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    BYTE_CONST = 2'd0,
    BYTE_INPUT = 2'd1,
    BYTE_SLC   = 2'd2
  } byte_src_t;

  typedef enum logic [2:0] {
    W_POWER_UP = 3'd0,
    W_SETTLE   = 3'd1,
    W_FIRST    = 3'd2,
    W_SECOND   = 3'd3,
    W_SLOW     = 3'd4
  } wait_sel_t;

  localparam logic [PC_W-1:0] PC_INIT  = 5'd0;
  localparam logic [PC_W-1:0] PC_CMD   = 5'd13;
  localparam logic [PC_W-1:0] PC_CLEAR = 5'd15;
  localparam logic [PC_W-1:0] PC_HOME  = 5'd17;
  localparam logic [PC_W-1:0] PC_TEXT  = 5'd19;
  localparam logic [PC_W-1:0] PC_CHAR  = 5'd22;
  localparam logic [PC_W-1:0] PC_LAST  = 5'd23;

  typedef struct packed {
    logic            emit;
    logic            strobe;
    logic            rs;
    byte_src_t       byte_src;
    logic [7:0]      const_byte;
    logic            nib_hi;
    wait_sel_t       wait_sel;
    logic            last;
    logic            skip;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic [5:0]  chars_per_line;
    logic [7:0]  second_line_command;
    logic [9:0]  strobe_settle_us;
    logic [13:0] slow_command_wait_us;
  } cfg_t;

  typedef struct packed {
    logic       fire;
    ucode_t     word;
    logic [7:0] byte_value;
  } seq_ctrl_t;

  function automatic ucode_t ev(input logic strobe, input logic rs, input byte_src_t src,
                                input logic [7:0] cb, input logic hi, input wait_sel_t ws,
                                input logic last);
    ucode_t w;
    w.emit = 1'b1;
    w.strobe = strobe;
    w.rs = rs;
    w.byte_src = src;
    w.const_byte = cb;
    w.nib_hi = hi;
    w.wait_sel = ws;
    w.last = last;
    w.skip = 1'b0;
    w.target = '0;
    return w;
  endfunction

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      // power-up initialisation
      5'd0:  w = ev(1'b0, 1'b0, BYTE_CONST, 8'h00, 1'b0, W_POWER_UP, 1'b0);
      5'd1:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h03, 1'b0, W_FIRST, 1'b0);
      5'd2:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h03, 1'b0, W_SECOND, 1'b0);
      5'd3:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h03, 1'b0, W_SETTLE, 1'b0);
      5'd4:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h02, 1'b0, W_SETTLE, 1'b0);
      5'd5:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h28, 1'b1, W_SETTLE, 1'b0);
      5'd6:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h28, 1'b0, W_SETTLE, 1'b0);
      5'd7:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h0E, 1'b1, W_SETTLE, 1'b0);
      5'd8:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h0E, 1'b0, W_SETTLE, 1'b0);
      5'd9:  w = ev(1'b1, 1'b0, BYTE_CONST, 8'h01, 1'b1, W_SETTLE, 1'b0);
      5'd10: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h01, 1'b0, W_SLOW, 1'b0);
      5'd11: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h06, 1'b1, W_SETTLE, 1'b0);
      5'd12: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h06, 1'b0, W_SETTLE, 1'b1);
      // raw command byte
      5'd13: w = ev(1'b1, 1'b0, BYTE_INPUT, 8'h00, 1'b1, W_SETTLE, 1'b0);
      5'd14: w = ev(1'b1, 1'b0, BYTE_INPUT, 8'h00, 1'b0, W_SETTLE, 1'b1);
      // clear and home
      5'd15: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h01, 1'b1, W_SETTLE, 1'b0);
      5'd16: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h01, 1'b0, W_SLOW, 1'b1);
      5'd17: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h02, 1'b1, W_SETTLE, 1'b0);
      5'd18: w = ev(1'b1, 1'b0, BYTE_CONST, 8'h02, 1'b0, W_SLOW, 1'b1);
      // text: skip the line jump unless it is due
      5'd19: begin
        w.skip = 1'b1;
        w.target = PC_CHAR;
      end
      5'd20: w = ev(1'b1, 1'b0, BYTE_SLC, 8'h00, 1'b1, W_SETTLE, 1'b0);
      5'd21: w = ev(1'b1, 1'b0, BYTE_SLC, 8'h00, 1'b0, W_SETTLE, 1'b0);
      5'd22: w = ev(1'b1, 1'b1, BYTE_INPUT, 8'h00, 1'b1, W_SETTLE, 1'b0);
      5'd23: w = ev(1'b1, 1'b1, BYTE_INPUT, 8'h00, 1'b0, W_SETTLE, 1'b1);
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### design/clni_req_if.sv
// request channel of the character lcd nibble interface
// standalone, no package use
`default_nettype none

interface clni_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] byte_value;
  logic       start_of_text;

  modport source(output valid, mode, byte_value, start_of_text, input ready);
  modport sink(input valid, mode, byte_value, start_of_text, output ready);
endinterface

`default_nettype wire

### design/clni_evt_if.sv
// pin event channel of the character lcd nibble interface
// standalone, no package use
`default_nettype none

interface clni_evt_if;
  logic        valid;
  logic        ready;
  logic        strobe_res;
  logic        reg_select;
  logic [3:0]  nibble;
  logic [15:0] wait_after_us;
  logic        last_event;

  modport source(output valid, strobe_res, reg_select, nibble, wait_after_us, last_event,
                 input ready);
  modport sink(input valid, strobe_res, reg_select, nibble, wait_after_us, last_event,
               output ready);
endinterface

`default_nettype wire

### design/clni_cfg_regs.sv
// apb register bank holding line length, second line command and wait settings
// depends on clni_pkg
`default_nettype none

module clni_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output clni_pkg::cfg_t    cfg
);

  logic            wr_en;
  clni_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign idx = clni_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chars_per_line <= clni_pkg::RST_CHARS_PER_LINE;
      cfg.second_line_command <= clni_pkg::RST_SECOND_LINE_CMD;
      cfg.strobe_settle_us <= clni_pkg::RST_STROBE_SETTLE;
      cfg.slow_command_wait_us <= clni_pkg::RST_SLOW_WAIT;
    end else if (wr_en) begin
      case (idx)
        clni_pkg::REG_CHARS_PER_LINE: cfg.chars_per_line <= pwdata[5:0];
        clni_pkg::REG_SECOND_LINE:    cfg.second_line_command <= pwdata[7:0];
        clni_pkg::REG_STROBE_SETTLE:  cfg.strobe_settle_us <= pwdata[9:0];
        clni_pkg::REG_SLOW_WAIT:      cfg.slow_command_wait_us <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      clni_pkg::REG_CHARS_PER_LINE: prdata = {26'd0, cfg.chars_per_line};
      clni_pkg::REG_SECOND_LINE:    prdata = {24'd0, cfg.second_line_command};
      clni_pkg::REG_STROBE_SETTLE:  prdata = {22'd0, cfg.strobe_settle_us};
      clni_pkg::REG_SLOW_WAIT:      prdata = {18'd0, cfg.slow_command_wait_us};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

### design/clni_sequencer.sv
// microcode sequencer: request intake, step counter, character count and line jump flag
// depends on clni_pkg and clni_req_if
`default_nettype none

module clni_sequencer (
  input  wire logic               clk,
  input  wire logic               rst,
  clni_req_if.sink                req,
  input  wire logic [5:0]         chars_per_line,
  input  wire logic               stall,
  output clni_pkg::seq_ctrl_t     ctrl
);

  logic                      busy;
  logic [clni_pkg::PC_W-1:0] pc;
  logic [5:0]                char_count;
  logic [5:0]                count_eff;
  logic                      line_jump;
  logic [7:0]                byte_value;
  logic                      accept;
  logic                      known_mode;
  logic                      advance;
  clni_pkg::ucode_t          word;
  clni_pkg::mode_t           mode;
  logic [clni_pkg::PC_W-1:0] entry;

  assign req.ready = !busy && !rst;
  assign accept = req.valid && !busy;
  assign mode = clni_pkg::mode_t'(req.mode);
  assign count_eff = req.start_of_text ? 6'd0 : char_count;
  assign word = clni_pkg::ucode_rom(pc);
  assign advance = busy && !stall;

  always_comb begin
    known_mode = 1'b1;
    case (mode)
      clni_pkg::MODE_INIT:  entry = clni_pkg::PC_INIT;
      clni_pkg::MODE_CMD:   entry = clni_pkg::PC_CMD;
      clni_pkg::MODE_CLEAR: entry = clni_pkg::PC_CLEAR;
      clni_pkg::MODE_HOME:  entry = clni_pkg::PC_HOME;
      clni_pkg::MODE_TEXT:  entry = clni_pkg::PC_TEXT;
      default: begin
        entry = clni_pkg::PC_INIT;
        known_mode = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= clni_pkg::PC_INIT;
      char_count <= 6'd0;
      line_jump <= 1'b0;
    end else if (accept) begin
      if (known_mode) begin
        busy <= 1'b1;
        pc <= entry;
      end
      if (mode == clni_pkg::MODE_TEXT) begin
        line_jump <= (count_eff == chars_per_line) && (count_eff != clni_pkg::COUNT_MAX);
        if (count_eff != clni_pkg::COUNT_MAX) begin
          char_count <= count_eff + 6'd1;
        end else begin
          char_count <= count_eff;
        end
      end
    end else if (advance) begin
      if (word.skip && !line_jump) begin
        pc <= word.target;
      end else begin
        pc <= pc + clni_pkg::PC_W'(1);
      end
      if (word.last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_value <= req.byte_value;
    end
  end

  assign ctrl.fire = advance && word.emit;
  assign ctrl.word = word;
  assign ctrl.byte_value = byte_value;

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && known_mode |=> busy)
    else $error("known request did not start the sequencer");

  a_bad_mode_count: assert property (@(posedge clk) disable iff (rst)
    accept && !known_mode |=> $stable(char_count) && !busy)
    else $error("undefined request changed state");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(char_count))
    else $error("character count moved during a run");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> pc <= clni_pkg::PC_LAST)
    else $error("step counter left the program");

endmodule

`default_nettype wire

### design/clni_datapath.sv
// event datapath: byte and nibble select, wait adder and output register
// depends on clni_pkg and clni_evt_if
`default_nettype none

module clni_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  clni_pkg::seq_ctrl_t     ctrl,
  input  clni_pkg::cfg_t          cfg,
  output logic                    stall,
  clni_evt_if.source              evt
);

  logic [7:0]  sel_byte;
  logic [3:0]  nibble_next;
  logic [15:0] extra;
  logic [15:0] wait_next;
  logic [15:0] settle;

  assign settle = {6'd0, cfg.strobe_settle_us};
  assign stall = evt.valid && !evt.ready;

  always_comb begin
    case (ctrl.word.byte_src)
      clni_pkg::BYTE_CONST: sel_byte = ctrl.word.const_byte;
      clni_pkg::BYTE_INPUT: sel_byte = ctrl.byte_value;
      clni_pkg::BYTE_SLC:   sel_byte = cfg.second_line_command;
      default:              sel_byte = 8'd0;
    endcase
    nibble_next = ctrl.word.nib_hi ? sel_byte[7:4] : sel_byte[3:0];
  end

  always_comb begin
    case (ctrl.word.wait_sel)
      clni_pkg::W_FIRST:  extra = clni_pkg::WAIT_FIRST_EXTRA;
      clni_pkg::W_SECOND: extra = clni_pkg::WAIT_SECOND_EXTRA;
      clni_pkg::W_SLOW:   extra = {2'd0, cfg.slow_command_wait_us};
      default:            extra = 16'd0;
    endcase
    if (ctrl.word.wait_sel == clni_pkg::W_POWER_UP) begin
      wait_next = clni_pkg::WAIT_POWER_UP;
    end else begin
      wait_next = settle + extra;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt.valid <= 1'b0;
    end else if (ctrl.fire) begin
      evt.valid <= 1'b1;
    end else if (evt.ready) begin
      evt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.fire) begin
      evt.strobe_res <= ctrl.word.strobe;
      evt.reg_select <= ctrl.word.rs;
      evt.nibble <= nibble_next;
      evt.wait_after_us <= wait_next;
      evt.last_event <= ctrl.word.last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    stall |-> !ctrl.fire)
    else $error("held event overwritten");

  a_pure_wait: assert property (@(posedge clk) disable iff (rst)
    evt.valid && !evt.strobe_res |-> !evt.reg_select && evt.nibble == 4'd0)
    else $error("pure wait event drives pins");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    stall |=> evt.valid && $stable(evt.wait_after_us))
    else $error("stalled event changed");

endmodule

`default_nettype wire

### design/char_lcd_nibble_interface_top.sv
// character lcd 4-bit controller: one request in, a run of 2 to 13 pin events out
// the first event passes the step counter and the datapath output register; text first runs a skip step
// throughput: one event per cycle while the event channel is not stalled; a request holds the request
//   channel until its last event is issued, with the skip step added for text
// reset: synchronous rst restores register defaults, clears the character count,
//   the step counter and the event valid flag
`default_nettype none

module char_lcd_nibble_interface_top (
  input  wire logic        clk,
  input  wire logic        rst,
  clni_req_if.sink         req,
  clni_evt_if.source       evt,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  clni_pkg::cfg_t      cfg;
  clni_pkg::seq_ctrl_t ctrl;
  logic                stall;

  clni_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  clni_sequencer u_seq (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .chars_per_line (cfg.chars_per_line),
    .stall          (stall),
    .ctrl           (ctrl)
  );

  clni_datapath u_dp (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (ctrl),
    .cfg   (cfg),
    .stall (stall),
    .evt   (evt)
  );

endmodule

`default_nettype wire
